// File: src/assert_macros.svh
// assertion macros used by the scanner core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/wbps_pkg.sv
// shared types and constants of the wildcard byte pattern scanner
package wbps_pkg;

    // default for the largest usable signature length
    localparam int PATTERN_MAX_DEF = 32;
    // hard limit of the signature store
    localparam int SIG_LIMIT = 32;

    // fixed field widths
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 5;
    localparam int CFG_W    = 6;
    localparam int OFFSET_W = 32;

    typedef logic [BYTE_W-1:0] byte_t;

    // item kinds
    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_SCAN = 1'b1
    } opcode_t;

endpackage

// File: src/wildcard_byte_pattern_scanner_core.sv
// top level of the wildcard byte pattern scanner
//
// Input channel (in_valid / in_stall) carries one item per transfer: either a
// signature load (opcode 0: entry_index, entry_value, entry_wildcard) or one
// image byte to scan (opcode 1: data_byte, last_byte). The output channel
// (out_valid / out_stall) carries at most one result per image: matched=1 with
// the start offset at the first full match, or matched=0 with offset 0 when
// the last byte passes without a match. cfg_wr_en / cfg_wr_data set the
// signature length; write it only while no item is in flight.
// An item taken sits in the input register; its result is registered in the
// output register and is transferred from there while out_stall is low.
// Throughput: one item per cycle; the window shift, the per-entry alignment
// mux and the masked compare all sit in one register-to-register path.
// The input register only holds when a result is due and the output register
// is still full and stalled; in_stall then rises and everything holds.
// Reset clears the signature to zero bytes without wildcards, sets the
// length to 1, empties both registers and rearms the scan.
module wildcard_byte_pattern_scanner_core
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,
    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                opcode,
    input  logic [INDEX_W-1:0]  entry_index,
    input  logic [BYTE_W-1:0]   entry_value,
    input  logic                entry_wildcard,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic                last_byte,
    // output channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic                matched,
    output logic [OFFSET_W-1:0] match_offset
);

    `include "assert_macros.svh"

    localparam int SIG_DEPTH = (PATTERN_MAX < SIG_LIMIT) ? PATTERN_MAX : SIG_LIMIT;
    localparam int LEN_W     = $clog2(SIG_DEPTH + 1);
    localparam logic [OFFSET_W-1:0] POS_MAX = '1;

    // effective signature length register
    logic [LEN_W-1:0] eff_len_reg;
    logic [LEN_W-1:0] eff_len_next;

    // input register
    logic               s1_valid_reg;
    opcode_t            s1_op_reg;
    logic [INDEX_W-1:0] s1_index_reg;
    byte_t              s1_value_reg;
    logic               s1_wild_reg;
    byte_t              s1_data_reg;
    logic               s1_last_reg;

    // scan state
    logic [OFFSET_W-1:0] pos_reg;
    logic [OFFSET_W-1:0] pos_next;
    logic                found_reg;

    // output register
    logic                out_valid_reg;
    logic                matched_reg;
    logic [OFFSET_W-1:0] offset_reg;

    logic                 in_take;
    logic                 is_scan;
    logic                 shift_en;
    logic                 hit;
    logic                 hit_flag;
    logic                 produce;
    logic                 out_free;
    logic                 advance;
    byte_t                sig_bytes [SIG_DEPTH];
    logic [SIG_DEPTH-1:0] sig_wild;

    // length clamp: zero acts as one, long values stop at the store depth
    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            eff_len_next = LEN_W'(1);
        end
        else if (32'(cfg_wr_data) > 32'(SIG_DEPTH))
        begin
            eff_len_next = LEN_W'(SIG_DEPTH);
        end
        else
        begin
            eff_len_next = LEN_W'(cfg_wr_data);
        end
    end

    // scan decisions for the item in the input register
    assign is_scan  = s1_valid_reg && (s1_op_reg == OP_SCAN);
    assign shift_en = advance && is_scan && !found_reg;
    assign pos_next = (pos_reg == POS_MAX) ? pos_reg : (pos_reg + OFFSET_W'(1));
    assign hit_flag = hit && (pos_next >= OFFSET_W'(eff_len_reg));
    assign produce  = is_scan && !found_reg && (hit_flag || s1_last_reg);

    // handshake: the pipe holds only when a result waits on a full, stalled output
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && (!produce || out_free);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    wbps_sig_store #(
        .SIG_DEPTH      (SIG_DEPTH)
    ) u_sig_store (
        .clk            (clk),
        .rst_n          (rst_n),
        .load_en        (advance && (s1_op_reg == OP_LOAD)),
        .entry_index    (s1_index_reg),
        .entry_value    (s1_value_reg),
        .entry_wildcard (s1_wild_reg),
        .sig_bytes      (sig_bytes),
        .sig_wild       (sig_wild)
    );

    wbps_matcher #(
        .SIG_DEPTH (SIG_DEPTH),
        .LEN_W     (LEN_W)
    ) u_matcher (
        .clk       (clk),
        .shift_en  (shift_en),
        .data_byte (s1_data_reg),
        .eff_len   (eff_len_reg),
        .sig_bytes (sig_bytes),
        .sig_wild  (sig_wild),
        .hit       (hit)
    );

    // length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_len_reg <= LEN_W'(1);
        end
        else if (cfg_wr_en)
        begin
            eff_len_reg <= eff_len_next;
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg    <= opcode_t'(opcode);
            s1_index_reg <= entry_index;
            s1_value_reg <= entry_value;
            s1_wild_reg  <= entry_wildcard;
            s1_data_reg  <= data_byte;
            s1_last_reg  <= last_byte;
        end
    end

    // position count and found flag, last byte rearms
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            found_reg <= 1'b0;
        end
        else if (advance && is_scan)
        begin
            if (s1_last_reg)
            begin
                pos_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (!found_reg)
            begin
                pos_reg <= pos_next;
                if (hit_flag)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            matched_reg <= hit_flag;
            offset_reg  <= hit_flag ? (pos_next - OFFSET_W'(eff_len_reg)) : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign matched      = matched_reg;
    assign match_offset = offset_reg;

    // a no-match result never carries an offset
    `ASSERT_SAME(a_nomatch_zero, out_valid_reg && !matched_reg, offset_reg == '0,
        "no-match result with nonzero offset")

    // a match before the image end blocks further results of that image
    `ASSERT_NEXT(a_found_set, advance && produce && hit_flag && !s1_last_reg, found_reg,
        "found flag not set after a match")

    // the position only moves forward until the image ends
    `ASSERT_NEXT(a_pos_mono, !(advance && is_scan && s1_last_reg),
        pos_reg >= $past(pos_reg), "byte position went backward")

endmodule

// File: src/wbps_sig_store.sv
// signature store: expected bytes and wildcard flags, written by load items
module wbps_sig_store
    import wbps_pkg::*;
#(
    parameter int SIG_DEPTH = PATTERN_MAX_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load_en,
    input  logic [INDEX_W-1:0]   entry_index,
    input  byte_t                entry_value,
    input  logic                 entry_wildcard,
    output byte_t                sig_bytes [SIG_DEPTH],
    output logic [SIG_DEPTH-1:0] sig_wild
);

    byte_t                sig_bytes_reg [SIG_DEPTH];
    logic [SIG_DEPTH-1:0] sig_wild_reg;

    // per-entry write decode, indexes beyond the store are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < SIG_DEPTH; j++)
            begin
                sig_bytes_reg[j] <= '0;
            end
            sig_wild_reg <= '0;
        end
        else
        begin
            for (int j = 0; j < SIG_DEPTH; j++)
            begin
                if (load_en && (32'(entry_index) == 32'(j)))
                begin
                    sig_bytes_reg[j] <= entry_value;
                    sig_wild_reg[j]  <= entry_wildcard;
                end
            end
        end
    end

    assign sig_bytes = sig_bytes_reg;
    assign sig_wild  = sig_wild_reg;

endmodule

// File: src/wbps_matcher.sv
// sliding byte window and parallel masked compare against the signature
module wbps_matcher
    import wbps_pkg::*;
#(
    parameter int SIG_DEPTH = PATTERN_MAX_DEF,
    parameter int LEN_W     = $clog2(SIG_DEPTH + 1)
)
(
    input  logic                 clk,
    input  logic                 shift_en,
    input  byte_t                data_byte,
    input  logic [LEN_W-1:0]     eff_len,
    input  byte_t                sig_bytes [SIG_DEPTH],
    input  logic [SIG_DEPTH-1:0] sig_wild,
    output logic                 hit
);

    localparam int AGE_W = (SIG_DEPTH > 1) ? $clog2(SIG_DEPTH) : 1;

    // window by age: entry 0 is the newest byte
    byte_t win_reg  [SIG_DEPTH];
    byte_t win_next [SIG_DEPTH];

    // window as it stands once the incoming byte is in
    always_comb
    begin
        win_next[0] = data_byte;
        for (int a = 1; a < SIG_DEPTH; a++)
        begin
            win_next[a] = win_reg[a-1];
        end
    end

    // signature entry j lines up with the byte eff_len-1-j transfers old
    always_comb
    begin
        int age;
        hit = 1'b1;
        for (int j = 0; j < SIG_DEPTH; j++)
        begin
            age = int'(eff_len) - 1 - j;
            if (j < int'(eff_len))
            begin
                if (!sig_wild[j] && (win_next[AGE_W'(age)] != sig_bytes[j]))
                begin
                    hit = 1'b0;
                end
            end
        end
    end

    // bytes older than the current image never affect a result, no reset needed
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            win_reg <= win_next;
        end
    end

endmodule
